// File: hdl/efl_pkg.sv
`default_nettype none
package efl_pkg;

   localparam int ENTRIES       = 16;
   localparam int IDX_WIDTH     = $clog2(ENTRIES);
   localparam int KEY_WIDTH     = 64;
   localparam int EPOCH_WIDTH   = 64;
   localparam int PAYLOAD_WIDTH = 32;

   typedef enum logic [1:0] {
      OP_LOOKUP     = 2'd0,
      OP_FILL       = 2'd1,
      OP_INVALIDATE = 2'd2
   } op_type;

   typedef logic [IDX_WIDTH-1:0]     idx_type;
   typedef logic [KEY_WIDTH-1:0]     key_type;
   typedef logic [EPOCH_WIDTH-1:0]   epoch_type;
   typedef logic [PAYLOAD_WIDTH-1:0] payload_type;

endpackage
`default_nettype wire

// File: hdl/epoch_flushed_lookup_cache.sv
`default_nettype none
// Channel   Direction  Ports
// req_      in         valid, stall, operation, lookup_key, access_epoch,
//                      fill_present, fill_payload
// rsp_      out        valid, stall, hit, registered, payload
//
// One request per cycle while req_stall is low; a request passes through
// the input register, then the result register, whose outputs drive rsp_.
// Cache state is updated as the request moves into the result register, so
// back-to-back requests always see the effect of the one before them.
// Reset clears all valid marks, the stored epoch and the fill pointer.
// A stalled response holds in place; req_stall rises only when both
// registers are full and rsp_stall is high.
module epoch_flushed_lookup_cache
   import efl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_operation,
   input  wire logic [KEY_WIDTH-1:0]     req_lookup_key,
   input  wire logic [EPOCH_WIDTH-1:0]   req_access_epoch,
   input  wire logic                     req_fill_present,
   input  wire logic [PAYLOAD_WIDTH-1:0] req_fill_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_registered,
   output logic [PAYLOAD_WIDTH-1:0]      rsp_payload
);

   // input register
   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   key_type     s1_key_ff;
   epoch_type   s1_epoch_ff;
   logic        s1_present_ff;
   payload_type s1_payload_ff;

   // cache state
   epoch_type         stored_epoch_ff, stored_epoch_in;
   logic [ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   key_type           entry_key_ff     [ENTRIES];
   logic [ENTRIES-1:0] entry_present_ff;
   payload_type       entry_payload_ff [ENTRIES];
   idx_type           fill_ptr_ff, fill_ptr_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_hit_ff, rsp_hit_in;
   logic        rsp_reg_ff, rsp_reg_in;
   payload_type rsp_payload_ff, rsp_payload_in;

   logic               s1_adv;
   logic               epoch_same;
   logic [ENTRIES-1:0] live;
   logic [ENTRIES-1:0] match;
   logic               any_match;
   logic               sel_present;
   payload_type        sel_payload;
   idx_type            ptr_eff;
   logic [ENTRIES-1:0] write_en;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;

   always_comb begin
      epoch_same  = (stored_epoch_ff == s1_epoch_ff);
      live        = epoch_same ? entry_valid_ff : '0;
      ptr_eff     = epoch_same ? fill_ptr_ff : '0;
      sel_present = 1'b0;
      sel_payload = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = live[i] && (entry_key_ff[i] == s1_key_ff);
         if (match[i]) begin
            sel_present = sel_present | entry_present_ff[i];
            sel_payload = sel_payload | entry_payload_ff[i];
         end
      end
      any_match = |match;

      stored_epoch_in = stored_epoch_ff;
      entry_valid_in  = entry_valid_ff;
      fill_ptr_in     = fill_ptr_ff;
      write_en        = '0;
      rsp_hit_in      = 1'b0;
      rsp_reg_in      = 1'b0;
      rsp_payload_in  = '0;

      case (s1_op_ff)
         OP_LOOKUP: begin
            stored_epoch_in = s1_epoch_ff;
            entry_valid_in  = live;
            fill_ptr_in     = ptr_eff;
            rsp_hit_in      = any_match;
            rsp_reg_in      = any_match && sel_present;
            rsp_payload_in  = (any_match && sel_present) ? sel_payload : '0;
         end
         OP_FILL: begin
            stored_epoch_in = s1_epoch_ff;
            entry_valid_in  = live;
            fill_ptr_in     = ptr_eff;
            if (any_match) begin
               write_en = match;
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  write_en[i] = (ptr_eff == IDX_WIDTH'(i));
               end
               entry_valid_in = live | write_en;
               fill_ptr_in    = (ptr_eff == IDX_WIDTH'(ENTRIES - 1)) ? '0
                                : ptr_eff + IDX_WIDTH'(1);
            end
         end
         OP_INVALIDATE: begin
            stored_epoch_in = s1_epoch_ff;
            entry_valid_in  = '0;
            fill_ptr_in     = '0;
         end
         default: begin
            // unused code: leave state alone, answer all zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stored_epoch_ff <= '0;
         entry_valid_ff  <= '0;
         fill_ptr_ff     <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff    <= 1'b1;
            stored_epoch_ff <= stored_epoch_in;
            entry_valid_ff  <= entry_valid_in;
            fill_ptr_ff     <= fill_ptr_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_op_ff      <= req_operation;
         s1_key_ff     <= req_lookup_key;
         s1_epoch_ff   <= req_access_epoch;
         s1_present_ff <= req_fill_present;
         s1_payload_ff <= req_fill_payload;
      end
      if (s1_adv) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_reg_ff     <= rsp_reg_in;
         rsp_payload_ff <= rsp_payload_in;
         for (int i = 0; i < ENTRIES; i++) begin
            if (write_en[i]) begin
               entry_key_ff[i]     <= s1_key_ff;
               entry_present_ff[i] <= s1_present_ff;
               // negative fill keeps the old word; it is never reported
               if (s1_present_ff) begin
                  entry_payload_ff[i] <= s1_payload_ff;
               end
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_registered = rsp_reg_ff;
   assign rsp_payload    = rsp_payload_ff;

endmodule
`default_nettype wire

// File: hdl/efl_checker.sv
`default_nettype none
module efl_checker
   import efl_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_hit,
   input wire logic                     rsp_registered,
   input wire logic [PAYLOAD_WIDTH-1:0] rsp_payload
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload)
         && $stable(rsp_hit) && $stable(rsp_registered))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reg_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_registered |-> rsp_hit)
      else $error("registered without hit");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_registered |-> rsp_payload == '0)
      else $error("payload nonzero without registered entry");

   // with no response waiting the block never pushes back
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while response side empty");

endmodule

bind epoch_flushed_lookup_cache efl_checker u_efl_checker (.*);
`default_nettype wire
